@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fsp assertion failed");

// Check a property on every rising clock edge, reset included.
`define FSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fsp assertion failed, reset included");

`endif

@@ src/fsp_pkg.sv @@
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants for the two-machine flow shop scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

  localparam int IN_W   = 16;  // width of a time field on the ports
  localparam int IDX_W  = 6;   // width of job_index on the port
  localparam int SPAN_W = 23;  // width of makespan on the port

  localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

  // What each cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_SHIFT
  } cell_mode_t;

  // Batch sequencer.
  typedef enum logic [1:0] {
    S_LOAD,
    S_SETTLE,
    S_SPAN,
    S_EMIT
  } seq_state_t;

endpackage

`default_nettype wire

@@ src/fsp_cell.sv @@
// ----------------------------------------------------------------------------
// fsp_cell
// One slot of the sorting chain. In insert mode it keeps the earlier of its
// held job and the job arriving from the left, and passes the other one on
// through its pass register. In shift mode it takes its right neighbor's job.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_cell #(
  parameter int TW = 16,
  parameter int XW = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fsp_pkg::cell_mode_t mode,
  // job arriving from the left neighbor
  input  wire logic                in_ok,
  input  wire logic [TW-1:0]       in_t1,
  input  wire logic [TW-1:0]       in_t2,
  input  wire logic [XW-1:0]       in_idx,
  // held job of the right neighbor
  input  wire logic                nb_ok,
  input  wire logic [TW-1:0]       nb_t1,
  input  wire logic [TW-1:0]       nb_t2,
  input  wire logic [XW-1:0]       nb_idx,
  // held job
  output logic                     held_ok,
  output logic [TW-1:0]            held_t1,
  output logic [TW-1:0]            held_t2,
  output logic [XW-1:0]            held_idx,
  // job handed to the right neighbor
  output logic                     pass_ok,
  output logic [TW-1:0]            pass_t1,
  output logic [TW-1:0]            pass_t2,
  output logic [XW-1:0]            pass_idx
);
  import fsp_pkg::*;

  // 0: t1 < t2, 1: t1 = t2, 2: t1 > t2
  function automatic logic [1:0] job_class(input logic [TW-1:0] t1,
                                           input logic [TW-1:0] t2);
    logic [1:0] c;
    if (t1 < t2) c = 2'd0;
    else if (t1 == t2) c = 2'd1;
    else c = 2'd2;
    return c;
  endfunction

  // Johnson order, ties by arrival number, so the order is total.
  function automatic logic goes_before(
    input logic [TW-1:0] a1, input logic [TW-1:0] a2, input logic [XW-1:0] ai,
    input logic [TW-1:0] b1, input logic [TW-1:0] b2, input logic [XW-1:0] bi);
    logic [1:0] ca;
    logic [1:0] cb;
    logic       r;
    ca = job_class(a1, a2);
    cb = job_class(b1, b2);
    if (ca != cb) r = (ca < cb);
    else if (ca == 2'd2 && a2 != b2) r = (a2 > b2);
    else if (ca != 2'd2 && a1 != b1) r = (a1 < b1);
    else r = (ai < bi);
    return r;
  endfunction

  logic take_in;

  assign take_in = in_ok &&
                   (!held_ok || goes_before(in_t1, in_t2, in_idx,
                                            held_t1, held_t2, held_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      held_ok <= 1'b0;
      pass_ok <= 1'b0;
    end else begin
      case (mode)
        CM_INSERT: begin
          if (take_in) begin
            held_ok  <= in_ok;
            held_t1  <= in_t1;
            held_t2  <= in_t2;
            held_idx <= in_idx;
            pass_ok  <= held_ok;
            pass_t1  <= held_t1;
            pass_t2  <= held_t2;
            pass_idx <= held_idx;
          end else begin
            pass_ok  <= in_ok;
            pass_t1  <= in_t1;
            pass_t2  <= in_t2;
            pass_idx <= in_idx;
          end
        end
        CM_SHIFT: begin
          held_ok  <= nb_ok;
          held_t1  <= nb_t1;
          held_t2  <= nb_t2;
          held_idx <= nb_idx;
          pass_ok  <= 1'b0;
        end
        default: begin
          pass_ok <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/two_machine_flow_shop_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// two_machine_flow_shop_scheduler_unit
// Loads a batch of jobs into a chain of sorting cells, orders them by
// Johnson's rule, computes the two-machine makespan and emits the sequence.
// ----------------------------------------------------------------------------
// Loading takes one job beat per cycle; each job ripples down the cell chain.
// After the last job the chain settles, then it is rotated once through the
// makespan accumulator, then the n results follow, one result per cycle while
// out_stall is low.
// Input is stalled from the last job until the final result beat is taken.
// Reset (synchronous) empties the chain and the batch counters.
`default_nettype none

module two_machine_flow_shop_scheduler_unit #(
  parameter int MAX_JOBS  = 64,
  parameter int TIME_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [fsp_pkg::IN_W-1:0]   time_m1,
  input  wire logic [fsp_pkg::IN_W-1:0]   time_m2,
  input  wire logic                       last_job,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [fsp_pkg::IDX_W-1:0]       job_index,
  output logic [fsp_pkg::SPAN_W-1:0]      makespan,
  output logic                            end_of_sequence,
  output logic                            overflow
);
  import fsp_pkg::*;

  `include "assert_macros.svh"

  localparam int TW    = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
  localparam int XW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int SUM_W = TW + XW + 2;
  localparam int ACC_W = (SUM_W > SPAN_W + 1) ? SUM_W : SPAN_W + 1;

  seq_state_t state;
  seq_state_t state_next;
  cell_mode_t mode;

  logic [XW-1:0]    step;
  logic             step_last;
  logic [CNT_W-1:0] job_count;
  logic             dropped_flag;
  logic [ACC_W-1:0] c1;
  logic [ACC_W-1:0] c2;
  logic [ACC_W-1:0] c1_next;
  logic [ACC_W-1:0] c2_max;

  logic in_beat;
  logic out_beat;
  logic room;

  logic [MAX_JOBS-1:0] h_ok;
  logic [TW-1:0]       h_t1  [MAX_JOBS];
  logic [TW-1:0]       h_t2  [MAX_JOBS];
  logic [XW-1:0]       h_idx [MAX_JOBS];
  logic [MAX_JOBS-1:0] p_ok;
  logic [TW-1:0]       p_t1  [MAX_JOBS];
  logic [TW-1:0]       p_t2  [MAX_JOBS];
  logic [XW-1:0]       p_idx [MAX_JOBS];

  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign room      = job_count < CNT_W'(MAX_JOBS);
  assign step_last = (step == XW'(MAX_JOBS - 1));

  // --- cell chain ----------------------------------------------------------
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic          l_ok;
    logic [TW-1:0] l_t1;
    logic [TW-1:0] l_t2;
    logic [XW-1:0] l_idx;
    logic          r_ok;
    logic [TW-1:0] r_t1;
    logic [TW-1:0] r_t2;
    logic [XW-1:0] r_idx;

    if (i == 0) begin : g_head
      assign l_ok  = in_beat && room;
      assign l_t1  = time_m1[TW-1:0];
      assign l_t2  = time_m2[TW-1:0];
      assign l_idx = job_count[XW-1:0];
    end else begin : g_mid
      assign l_ok  = p_ok[i-1];
      assign l_t1  = p_t1[i-1];
      assign l_t2  = p_t2[i-1];
      assign l_idx = p_idx[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      // wrap around while rotating for the makespan, drain empty otherwise
      assign r_ok  = (state == S_SPAN) && h_ok[0];
      assign r_t1  = h_t1[0];
      assign r_t2  = h_t2[0];
      assign r_idx = h_idx[0];
    end else begin : g_body
      assign r_ok  = h_ok[i+1];
      assign r_t1  = h_t1[i+1];
      assign r_t2  = h_t2[i+1];
      assign r_idx = h_idx[i+1];
    end

    fsp_cell #(
      .TW (TW),
      .XW (XW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .mode     (mode),
      .in_ok    (l_ok),
      .in_t1    (l_t1),
      .in_t2    (l_t2),
      .in_idx   (l_idx),
      .nb_ok    (r_ok),
      .nb_t1    (r_t1),
      .nb_t2    (r_t2),
      .nb_idx   (r_idx),
      .held_ok  (h_ok[i]),
      .held_t1  (h_t1[i]),
      .held_t2  (h_t2[i]),
      .held_idx (h_idx[i]),
      .pass_ok  (p_ok[i]),
      .pass_t1  (p_t1[i]),
      .pass_t2  (p_t2[i]),
      .pass_idx (p_idx[i])
    );
  end

  // --- sequencer -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mode       = CM_HOLD;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        mode     = CM_INSERT;
        if (in_beat && last_job) state_next = S_SETTLE;
      end
      S_SETTLE: begin
        mode = CM_INSERT;
        if (step_last) state_next = S_SPAN;
      end
      S_SPAN: begin
        mode = CM_SHIFT;
        if (step_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_beat) begin
          mode = CM_SHIFT;
          if (end_of_sequence) state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      job_count    <= '0;
      dropped_flag <= 1'b0;
    end else begin
      if (state == S_SETTLE || state == S_SPAN) begin
        step <= step_last ? '0 : step + XW'(1);
      end else begin
        step <= '0;
      end
      if (state == S_LOAD && in_beat) begin
        if (room) job_count <= job_count + CNT_W'(1);
        else dropped_flag <= 1'b1;
      end
      if (out_beat) begin
        job_count <= job_count - CNT_W'(1);
        if (end_of_sequence) dropped_flag <= 1'b0;
      end
    end
  end

  // --- makespan: c1 += t1; c2 = max(c2, c1) + t2 --------------------------
  assign c1_next = c1 + ACC_W'(h_t1[0]);
  assign c2_max  = (c2 > c1_next) ? c2 : c1_next;

  always_ff @(posedge clk) begin
    if (state == S_SETTLE) begin
      c1 <= '0;
      c2 <= '0;
    end else if (state == S_SPAN && h_ok[0]) begin
      c1 <= c1_next;
      c2 <= c2_max + ACC_W'(h_t2[0]);
    end
  end

  // --- result beat ---------------------------------------------------------
  assign job_index       = IDX_W'(h_idx[0]);
  assign makespan        = (c2 > ACC_W'(SPAN_MAX)) ? SPAN_MAX : c2[SPAN_W-1:0];
  assign end_of_sequence = (job_count == CNT_W'(1));
  assign overflow        = dropped_flag;

  // --- checks --------------------------------------------------------------
  `FSP_ASSERT(a_count_range, clk, rst, job_count <= CNT_W'(MAX_JOBS))
  `FSP_ASSERT(a_emit_nonempty, clk, rst, out_valid |-> (job_count != '0 && h_ok[0]))
  `FSP_ASSERT(a_batch_closes, clk, rst,
    (out_beat && end_of_sequence) |=> (job_count == '0 && !dropped_flag && !in_stall))
  `FSP_ASSERT(a_no_overlap, clk, rst, !(in_beat && out_valid))

endmodule

`default_nettype wire
